// ===== rtl/ccd_pkg.sv =====
// Package for the crank/cam trigger decoder.
// Holds the configuration and result types and the command, register and filter codes.
// No dependencies.
package ccd_pkg;

    localparam int TS_W       = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Edge source codes.
    localparam logic CMD_CRANK = 1'b0;
    localparam logic CMD_CAM   = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CRANK_TEETH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESYNC      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER      = 2'd2;

    // Crank filter levels.
    localparam logic [1:0] FILT_OFF     = 2'd0;
    localparam logic [1:0] FILT_QUARTER = 2'd1;
    localparam logic [1:0] FILT_HALF    = 2'd2;
    localparam logic [1:0] FILT_3QUART  = 2'd3;

    localparam logic [7:0] RST_CRANK_TEETH = 8'd4;
    localparam logic       RST_RESYNC      = 1'b0;
    localparam logic [1:0] RST_FILTER      = FILT_QUARTER;

    // The previous crank time is placed this far back when sync is forced from a cam pulse.
    localparam logic [31:0] RPM_FIX_OFFSET = 32'd1500000;

    typedef struct packed {
        logic [7:0] crank_teeth;
        logic       resync_enable;
        logic [1:0] filter_level;
    } t_cfg;

    typedef struct packed {
        logic            accepted;
        logic [7:0]      tooth_number;
        logic            in_sync;
        logic            second_revolution;
        logic [15:0]     revolutions;
        logic [7:0]      sync_losses;
        logic [TS_W-1:0] last_tooth_time;
        logic [TS_W-1:0] prev_tooth_time;
        logic [TS_W-1:0] tooth_one_time;
        logic [TS_W-1:0] prev_tooth_one_time;
    } t_result;

endpackage

// ===== rtl/ccd_ifs.sv =====
// Handshake interfaces of the crank/cam trigger decoder: edge events in, results out.
// Depends on ccd_pkg.
interface ccd_edge_if import ccd_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            cmd;
    logic [TS_W-1:0] timestamp;

    modport source (output valid, cmd, timestamp, input ready);
    modport sink   (input valid, cmd, timestamp, output ready);
endinterface

interface ccd_result_if import ccd_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            accepted;
    logic [7:0]      tooth_number;
    logic            in_sync;
    logic            second_revolution;
    logic [15:0]     revolutions;
    logic [7:0]      sync_losses;
    logic [TS_W-1:0] last_tooth_time;
    logic [TS_W-1:0] prev_tooth_time;
    logic [TS_W-1:0] tooth_one_time;
    logic [TS_W-1:0] prev_tooth_one_time;

    modport source (output valid, accepted, tooth_number, in_sync, second_revolution,
                    revolutions, sync_losses, last_tooth_time, prev_tooth_time,
                    tooth_one_time, prev_tooth_one_time, input ready);
    modport sink   (input valid, accepted, tooth_number, in_sync, second_revolution,
                    revolutions, sync_losses, last_tooth_time, prev_tooth_time,
                    tooth_one_time, prev_tooth_one_time, output ready);
endinterface

// ===== rtl/ccd_in_reg.sv =====
// Input register of the crank/cam trigger decoder: holds one edge event.
// Depends on ccd_pkg.
module ccd_in_reg import ccd_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_cmd,
    input  logic [TS_W-1:0] i_timestamp,
    input  logic            i_advance,
    output logic            o_ready,
    output logic            o_valid,
    output logic            o_cmd,
    output logic [TS_W-1:0] o_timestamp
);

    logic            r_valid;
    logic            r_cmd;
    logic [TS_W-1:0] r_timestamp;

    // The register frees up in the same cycle its event moves on.
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd       <= i_cmd;
            r_timestamp <= i_timestamp;
        end
    end

    assign o_valid     = r_valid;
    assign o_cmd       = r_cmd;
    assign o_timestamp = r_timestamp;

endmodule

// ===== rtl/ccd_core.sv =====
// Decoder state and the single-pass update for one crank or cam edge.
// Depends on ccd_pkg.
module ccd_core import ccd_pkg::*; #(
    parameter int TIME_BITS = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cfg            i_cfg,
    input  logic            i_fire,
    input  logic            i_cmd,
    input  logic [TS_W-1:0] i_timestamp,
    output t_result         o_result
);

    typedef logic [TIME_BITS-1:0] t_time;

    function automatic t_time gap_x1_5(t_time g);
        logic [TIME_BITS:0] s;
        s = {1'b0, g} + {2'b00, g[TIME_BITS-1:1]};
        return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
    endfunction

    function automatic t_time gap_x4(t_time g);
        return (g[TIME_BITS-1:TIME_BITS-2] != 2'b00) ? '1 : {g[TIME_BITS-3:0], 2'b00};
    endfunction

    function automatic t_time crank_filter_of(t_time g, logic [1:0] level);
        t_time f;
        unique case (level)
            FILT_OFF:     f = '0;
            FILT_QUARTER: f = g >> 2;
            FILT_HALF:    f = g >> 1;
            FILT_3QUART:  f = (g >> 1) + (g >> 2) + t_time'(g[1:0] == 2'b11);
            default:      f = '0;
        endcase
        return f;
    endfunction

    logic [7:0]  r_tooth_count, n_tooth_count;
    logic [7:0]  r_sync_check, n_sync_check;
    logic [7:0]  r_cam_count, n_cam_count;
    t_time       r_crank_filter, n_crank_filter;
    t_time       r_cam_filter, n_cam_filter;
    t_time       r_last_gap, n_last_gap;
    t_time       r_crank_time, n_crank_time;
    t_time       r_crank_prev_time, n_crank_prev_time;
    t_time       r_cam_time, n_cam_time;
    t_time       r_first_time, n_first_time;
    t_time       r_first_prev_time, n_first_prev_time;
    logic        r_sync, n_sync;
    logic        r_phase, n_phase;
    logic [15:0] r_rev_count, n_rev_count;
    logic [7:0]  r_loss_count, n_loss_count;

    t_time      t;
    t_time      crank_gap;
    t_time      cam_gap;
    t_time      fix_time;
    logic [7:0] teeth_m1;
    logic [8:0] next_tooth;
    logic       accepted;

    assign t         = t_time'(i_timestamp);
    assign crank_gap = t - r_crank_time;
    assign cam_gap   = t - r_cam_time;
    assign fix_time  = t - t_time'(RPM_FIX_OFFSET);
    assign teeth_m1  = i_cfg.crank_teeth - 8'd1;

    always_comb begin
        n_tooth_count     = r_tooth_count;
        n_sync_check      = r_sync_check;
        n_cam_count       = r_cam_count;
        n_crank_filter    = r_crank_filter;
        n_cam_filter      = r_cam_filter;
        n_last_gap        = r_last_gap;
        n_crank_time      = r_crank_time;
        n_crank_prev_time = r_crank_prev_time;
        n_cam_time        = r_cam_time;
        n_first_time      = r_first_time;
        n_first_prev_time = r_first_prev_time;
        n_sync            = r_sync;
        n_phase           = r_phase;
        n_rev_count       = r_rev_count;
        n_loss_count      = r_loss_count;
        next_tooth        = {1'b0, r_tooth_count} + 9'd1;
        accepted          = 1'b0;

        if (i_fire && i_cmd == CMD_CRANK) begin
            // The gap is recorded even when the edge is filtered out.
            n_last_gap = crank_gap;
            if (crank_gap >= r_crank_filter) begin
                accepted = 1'b1;
                if (r_sync_check != 8'd0) begin
                    n_sync_check = r_sync_check + 8'd1;
                end
                if (r_cam_filter <= crank_gap) begin
                    n_cam_filter = gap_x1_5(crank_gap);
                end
                n_crank_prev_time = r_crank_time;
                n_crank_time      = t;
                if (r_sync) begin
                    // The wrap test sees the count before it wraps at eight bits.
                    if (next_tooth == 9'd1 || next_tooth > {1'b0, i_cfg.crank_teeth}) begin
                        next_tooth        = 9'd1;
                        n_phase           = !r_phase;
                        n_first_prev_time = r_first_time;
                        n_first_time      = t;
                        n_rev_count       = r_rev_count + 16'd1;
                    end
                    n_crank_filter = crank_filter_of(crank_gap, i_cfg.filter_level);
                end else if (r_cam_count == 8'd1 && n_sync_check == 8'd4) begin
                    next_tooth = 9'd2;
                    n_sync     = 1'b1;
                    n_phase    = 1'b0;
                end
                n_tooth_count = next_tooth[7:0];
            end
        end else if (i_fire) begin
            if (cam_gap < r_cam_filter) begin
                n_cam_filter = gap_x1_5(r_last_gap);
                n_sync_check = 8'd1;
            end else begin
                accepted   = 1'b1;
                n_cam_time = t;
                if (r_cam_count == 8'd2 && r_sync_check == 8'd3) begin
                    // Cam sync pulse: gain sync, or check the tooth count against it.
                    if (!r_sync) begin
                        n_crank_time      = t;
                        n_crank_prev_time = fix_time;
                        n_tooth_count     = teeth_m1;
                        n_sync            = 1'b1;
                    end else begin
                        if (r_tooth_count != teeth_m1 && r_rev_count > 16'd2) begin
                            n_loss_count = r_loss_count + 8'd1;
                        end
                        if (i_cfg.resync_enable) begin
                            n_tooth_count = teeth_m1;
                        end
                    end
                    n_phase      = 1'b1;
                    n_cam_filter = gap_x4(r_last_gap);
                    n_cam_count  = 8'd1;
                end else if (!r_sync && r_tooth_count >= 8'd3 && r_cam_count == 8'd0) begin
                    n_crank_time      = t;
                    n_crank_prev_time = fix_time;
                    n_tooth_count     = 8'd1;
                    n_phase           = 1'b1;
                    n_sync            = 1'b1;
                end else begin
                    n_cam_filter = gap_x1_5(r_last_gap);
                    n_cam_count  = r_cam_count + 8'd1;
                    n_sync_check = 8'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tooth_count     <= '0;
            r_sync_check      <= '0;
            r_cam_count       <= '0;
            r_crank_filter    <= '0;
            r_cam_filter      <= '0;
            r_last_gap        <= '0;
            r_crank_time      <= '0;
            r_crank_prev_time <= '0;
            r_cam_time        <= '0;
            r_first_time      <= '0;
            r_first_prev_time <= '0;
            r_sync            <= 1'b0;
            r_phase           <= 1'b0;
            r_rev_count       <= '0;
            r_loss_count      <= '0;
        end else begin
            r_tooth_count     <= n_tooth_count;
            r_sync_check      <= n_sync_check;
            r_cam_count       <= n_cam_count;
            r_crank_filter    <= n_crank_filter;
            r_cam_filter      <= n_cam_filter;
            r_last_gap        <= n_last_gap;
            r_crank_time      <= n_crank_time;
            r_crank_prev_time <= n_crank_prev_time;
            r_cam_time        <= n_cam_time;
            r_first_time      <= n_first_time;
            r_first_prev_time <= n_first_prev_time;
            r_sync            <= n_sync;
            r_phase           <= n_phase;
            r_rev_count       <= n_rev_count;
            r_loss_count      <= n_loss_count;
        end
    end

    always_comb begin
        o_result.accepted            = accepted;
        o_result.tooth_number        = n_tooth_count;
        o_result.in_sync             = n_sync;
        o_result.second_revolution   = n_phase;
        o_result.revolutions         = n_rev_count;
        o_result.sync_losses         = n_loss_count;
        o_result.last_tooth_time     = TS_W'(n_crank_time);
        o_result.prev_tooth_time     = TS_W'(n_crank_prev_time);
        o_result.tooth_one_time      = TS_W'(n_first_time);
        o_result.prev_tooth_one_time = TS_W'(n_first_prev_time);
    end

endmodule

// ===== rtl/ccd_out_reg.sv =====
// Result register of the crank/cam trigger decoder, held until the sink takes it.
// Depends on ccd_pkg.
module ccd_out_reg import ccd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_can_load,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== rtl/crank_cam_trigger_decoder.sv =====
// Top level of the crank/cam trigger decoder: configuration registers and the
// input register, decode core and result register. Depends on ccd_pkg and ccd_ifs.
//
//  Port        Direction  Carries
//  i_edge      in         cmd (crank 0 / cam 1), timestamp
//  o_result    out        accepted, tooth, sync, phase, counters, edge times
//  i_cfg_*     in         write enable, register index, write data
//
// An edge passes from the input register through the decode logic into the result
// register. One edge is accepted per cycle while the result register can load; the
// decoder state updates as the edge enters the result register.
// A stalled result holds both registers; the input still takes one edge while the
// result waits. Synchronous active-low reset clears state and loads config defaults.
module crank_cam_trigger_decoder import ccd_pkg::*; #(
    parameter int TIME_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ccd_edge_if.sink              i_edge,
    ccd_result_if.source          o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg            r_cfg;
    logic            s1_valid;
    logic            s1_cmd;
    logic [TS_W-1:0] s1_timestamp;
    logic            can_load;
    logic            fire;
    t_result         core_result;
    t_result         out_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.crank_teeth   <= RST_CRANK_TEETH;
            r_cfg.resync_enable <= RST_RESYNC;
            r_cfg.filter_level  <= RST_FILTER;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CRANK_TEETH: r_cfg.crank_teeth   <= i_cfg_data;
                REG_RESYNC:      r_cfg.resync_enable <= i_cfg_data[0];
                REG_FILTER:      r_cfg.filter_level  <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    ccd_in_reg u_in_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_edge.valid),
        .i_cmd       (i_edge.cmd),
        .i_timestamp (i_edge.timestamp),
        .i_advance   (can_load),
        .o_ready     (i_edge.ready),
        .o_valid     (s1_valid),
        .o_cmd       (s1_cmd),
        .o_timestamp (s1_timestamp)
    );

    assign fire = s1_valid && can_load;

    ccd_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_fire      (fire),
        .i_cmd       (s1_cmd),
        .i_timestamp (s1_timestamp),
        .o_result    (core_result)
    );

    ccd_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire),
        .i_result   (core_result),
        .i_ready    (o_result.ready),
        .o_can_load (can_load),
        .o_valid    (o_result.valid),
        .o_result   (out_result)
    );

    assign o_result.accepted            = out_result.accepted;
    assign o_result.tooth_number        = out_result.tooth_number;
    assign o_result.in_sync             = out_result.in_sync;
    assign o_result.second_revolution   = out_result.second_revolution;
    assign o_result.revolutions         = out_result.revolutions;
    assign o_result.sync_losses         = out_result.sync_losses;
    assign o_result.last_tooth_time     = out_result.last_tooth_time;
    assign o_result.prev_tooth_time     = out_result.prev_tooth_time;
    assign o_result.tooth_one_time      = out_result.tooth_one_time;
    assign o_result.prev_tooth_one_time = out_result.prev_tooth_one_time;

endmodule

// ===== rtl/ccd_checker.sv =====
// Port-level checks for the crank/cam trigger decoder, bound to the top level.
// Depends on ccd_pkg.
module ccd_checker import ccd_pkg::*; (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            i_in_ready,
    input logic            i_res_valid,
    input logic            i_res_ready,
    input logic            i_res_accepted,
    input logic [7:0]      i_res_tooth,
    input logic            i_res_sync,
    input logic            i_res_phase,
    input logic [15:0]     i_res_revs,
    input logic [7:0]      i_res_losses,
    input logic [TS_W-1:0] i_res_t0,
    input logic [TS_W-1:0] i_res_t1,
    input logic [TS_W-1:0] i_res_t2,
    input logic [TS_W-1:0] i_res_t3
);

    // A result that is not taken keeps its whole word.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable({i_res_accepted,
            i_res_tooth, i_res_sync, i_res_phase, i_res_revs, i_res_losses,
            i_res_t0, i_res_t1, i_res_t2, i_res_t3}))
        else $error("stalled result changed");

    // After each accepted edge a result is showing, its own or an earlier one held by a stall.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |-> ##2 i_res_valid)
        else $error("accepted edge produced no result");

    // Sync is never dropped once gained.
    a_sync_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_sync |=> !i_res_valid || i_res_sync)
        else $error("sync flag fell");

    // Before sync no revolution, phase or loss can have been counted.
    a_presync_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_sync |-> i_res_revs == 16'd0 && i_res_losses == 8'd0
            && !i_res_phase && i_res_t2 == '0 && i_res_t3 == '0)
        else $error("revolution state moved without sync");

endmodule

bind crank_cam_trigger_decoder ccd_checker u_ccd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_edge.valid),
    .i_in_ready     (i_edge.ready),
    .i_res_valid    (o_result.valid),
    .i_res_ready    (o_result.ready),
    .i_res_accepted (o_result.accepted),
    .i_res_tooth    (o_result.tooth_number),
    .i_res_sync     (o_result.in_sync),
    .i_res_phase    (o_result.second_revolution),
    .i_res_revs     (o_result.revolutions),
    .i_res_losses   (o_result.sync_losses),
    .i_res_t0       (o_result.last_tooth_time),
    .i_res_t1       (o_result.prev_tooth_time),
    .i_res_t2       (o_result.tooth_one_time),
    .i_res_t3       (o_result.prev_tooth_one_time)
);

// ===== sim/tb_crank_cam_trigger_decoder.sv =====
// Testbench for crank_cam_trigger_decoder: a self-checking run of crank and cam edge words.
// A scoreboard predicts each result. Depends on ccd_pkg, ccd_ifs and the decoder top level.
module tb_crank_cam_trigger_decoder;
    import ccd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 215;
    localparam int MAX_REPORTS  = 10;

    // Index with no register behind it; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // Sync check counts seen by a crank tooth and by a cam pulse.
    localparam logic [7:0] CHECK_AT_CRANK = 8'd4;
    localparam logic [7:0] CHECK_AT_CAM   = 8'd3;

    typedef struct {
        logic            cmd;
        logic [TS_W-1:0] ts;
    } t_edge_item;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ccd_edge_if   edge_bus ();
    ccd_result_if res_bus ();

    crank_cam_trigger_decoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_edge     (edge_bus),
        .o_result   (res_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Predicted decoder state and register copy.
    t_cfg            cfg;
    logic [7:0]      cur_tooth, chk_cnt, cam_seen;
    logic [TS_W-1:0] crank_gate, cam_gate, crank_gap;
    logic [TS_W-1:0] t_tooth, t_tooth_prev, t_cam, t_one, t_one_prev;
    logic            synced, phase;
    logic [15:0]     revs;
    logic [7:0]      losses;

    t_edge_item pending_edges[$];
    t_result    expected_decodes[$];

    logic edge_taken = 1'b0;
    logic res_taken  = 1'b0;
    int   send_idle  = 0, send_calm = 0;
    int   recv_idle  = 0, recv_calm = 0;
    int   cycle_cnt  = 0;
    int   mismatch_cnt = 0, checked_cnt = 0, passed_cnt = 0;
    int   crank_cnt = 0, cam_cnt = 0, settings_cnt = 0;

    // Stimulus generator state.
    logic [TS_W-1:0] now     = 32'd2000;
    logic [TS_W-1:0] cur_gap = 32'd200;

    function automatic logic [TS_W-1:0] times_1p5(input logic [TS_W-1:0] g);
        logic [TS_W:0] s;
        s = {1'b0, g} + {2'b0, g[TS_W-1:1]};
        return s[TS_W] ? '1 : s[TS_W-1:0];
    endfunction

    function automatic logic [TS_W-1:0] times_4(input logic [TS_W-1:0] g);
        return (g[TS_W-1:TS_W-2] != 2'b00) ? '1 : {g[TS_W-3:0], 2'b00};
    endfunction

    function automatic logic [TS_W-1:0] gate_of(input logic [TS_W-1:0] g);
        case (cfg.filter_level)
            FILT_QUARTER: return g >> 2;
            FILT_HALF:    return g >> 1;
            FILT_3QUART:  return (g >> 1) + (g >> 2) + ((g[1:0] == 2'b11) ? 1 : 0);
            default:      return '0;
        endcase
    endfunction

    task automatic reset_model();
        cfg.crank_teeth   = RST_CRANK_TEETH;
        cfg.resync_enable = RST_RESYNC;
        cfg.filter_level  = RST_FILTER;
        cur_tooth = '0; chk_cnt = '0; cam_seen = '0;
        crank_gate = '0; cam_gate = '0; crank_gap = '0;
        t_tooth = '0; t_tooth_prev = '0; t_cam = '0; t_one = '0; t_one_prev = '0;
        synced = 1'b0; phase = 1'b0; revs = '0; losses = '0;
    endtask

    task automatic decode_edge(input logic cmd, input logic [TS_W-1:0] t, output t_result r);
        logic [TS_W-1:0] gap;
        logic [8:0]      nxt;
        logic [7:0]      teeth_m1;
        logic            ok;
        ok = 1'b1;
        if (cmd == CMD_CRANK) begin
            gap = t - t_tooth;
            // The gap is kept even when the tooth is filtered out.
            crank_gap = gap;
            if (gap < crank_gate) begin
                ok = 1'b0;
            end else begin
                nxt = {1'b0, cur_tooth} + 9'd1;
                if (chk_cnt != 0) chk_cnt = chk_cnt + 8'd1;
                if (cam_gate <= gap) cam_gate = times_1p5(gap);
                t_tooth_prev = t_tooth;
                t_tooth = t;
                if (synced) begin
                    // The compare sees the count before it wraps at 8 bits.
                    if (nxt == 9'd1 || nxt > {1'b0, cfg.crank_teeth}) begin
                        nxt = 9'd1;
                        phase = ~phase;
                        t_one_prev = t_one;
                        t_one = t;
                        revs = revs + 16'd1;
                    end
                    crank_gate = gate_of(gap);
                end else if (cam_seen == 8'd1 && chk_cnt == CHECK_AT_CRANK) begin
                    nxt = 9'd2;
                    synced = 1'b1;
                    phase = 1'b0;
                end
                cur_tooth = nxt[7:0];
            end
        end else begin
            gap = t - t_cam;
            teeth_m1 = cfg.crank_teeth - 8'd1;
            if (gap < cam_gate) begin
                cam_gate = times_1p5(crank_gap);
                chk_cnt = 8'd1;
                ok = 1'b0;
            end else begin
                t_cam = t;
                if (cam_seen == 8'd2 && chk_cnt == CHECK_AT_CAM) begin
                    if (!synced) begin
                        t_tooth = t;
                        t_tooth_prev = t - RPM_FIX_OFFSET;
                        cur_tooth = teeth_m1;
                        synced = 1'b1;
                    end else begin
                        if (cur_tooth != teeth_m1 && revs > 16'd2) losses = losses + 8'd1;
                        if (cfg.resync_enable) cur_tooth = teeth_m1;
                    end
                    phase = 1'b1;
                    cam_gate = times_4(crank_gap);
                    cam_seen = 8'd1;
                end else if (!synced && cur_tooth >= 8'd3 && cam_seen == 8'd0) begin
                    t_tooth = t;
                    t_tooth_prev = t - RPM_FIX_OFFSET;
                    cur_tooth = 8'd1;
                    phase = 1'b1;
                    synced = 1'b1;
                end else begin
                    cam_gate = times_1p5(crank_gap);
                    cam_seen = cam_seen + 8'd1;
                    chk_cnt = 8'd1;
                end
            end
        end
        r.accepted            = ok;
        r.tooth_number        = cur_tooth;
        r.in_sync             = synced;
        r.second_revolution   = phase;
        r.revolutions         = revs;
        r.sync_losses         = losses;
        r.last_tooth_time     = t_tooth;
        r.prev_tooth_time     = t_tooth_prev;
        r.tooth_one_time      = t_one;
        r.prev_tooth_one_time = t_one_prev;
    endtask

    function automatic string show(input t_result r);
        return $sformatf("acc=%0d tooth=%0d sync=%0d phase=%0d revs=%0d losses=%0d %h %h %h %h",
                         r.accepted, r.tooth_number, r.in_sync, r.second_revolution,
                         r.revolutions, r.sync_losses, r.last_tooth_time, r.prev_tooth_time,
                         r.tooth_one_time, r.prev_tooth_one_time);
    endfunction

    // Wait draw per word: mostly a uniformly drawn wait, with occasional stretches of no waiting.
    function automatic int draw_idle(inout int calm);
        if (calm > 0) begin
            calm = calm - 1;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 5);
    endfunction

    function automatic logic [TS_W-1:0] pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(20, 5000);
        if (r < 95) return $urandom_range(100000, 3000000);
        return $urandom_range(32'h4000_0000, 32'h7FFF_FFFF);
    endfunction

    task automatic queue_edge(input logic cmd, input logic [TS_W-1:0] ts);
        t_edge_item it;
        it.cmd = cmd;
        it.ts  = ts;
        pending_edges.push_back(it);
        if (cmd == CMD_CRANK) crank_cnt++;
        else cam_cnt++;
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_CRANK_TEETH: cfg.crank_teeth   = data;
            REG_RESYNC:      cfg.resync_enable = data[0];
            REG_FILTER:      cfg.filter_level  = data[1:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_edges.size() != 0 || edge_bus.valid || expected_decodes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Random edges for one setting: mostly whole revolutions with cam pulses, plus noise.
    task automatic plan_phase(input int budget);
        int              target, n, a, k, kind;
        logic [TS_W-1:0] step;
        target = crank_cnt + cam_cnt + budget;
        while (crank_cnt + cam_cnt < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 65) begin
                if ($urandom_range(0, 99) < 15) cur_gap = pick_gap();
                n = (cfg.crank_teeth < 6) ? 6 : cfg.crank_teeth;
                a = $urandom_range(0, n - 3);
                // No cam, a single cam, or a pair two teeth apart that makes a sync pulse.
                k = $urandom_range(0, 9);
                for (int i = 0; i < n; i++) begin
                    step = cur_gap - (cur_gap >> 4) + $urandom_range(0, cur_gap >> 3);
                    if ((k != 0 && i == a) || (k > 2 && i == a + 2))
                        queue_edge(CMD_CAM, now + (step >> 1));
                    now = now + step;
                    queue_edge(CMD_CRANK, now);
                end
            end else if (kind < 80) begin
                repeat ($urandom_range(3, 10)) begin
                    now = now + $urandom_range(0, cur_gap >> 1);
                    queue_edge($urandom_range(0, 1) ? CMD_CAM : CMD_CRANK, now);
                end
            end else if (kind < 90) begin
                // A glitch shortly after the last tooth; the timeline itself does not move.
                queue_edge($urandom_range(0, 1) ? CMD_CAM : CMD_CRANK,
                           now + $urandom_range(1, (cur_gap >> 2) + 1));
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    now = $urandom();
                    queue_edge($urandom_range(0, 1) ? CMD_CAM : CMD_CRANK, now);
                end
            end
        end
    endtask

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    // Edge driver: one word at a time, with a drawn wait after each accepted word.
    always @(negedge i_clk) begin
        t_edge_item it;
        if (!i_rst_n) begin
            edge_bus.valid <= 1'b0;
        end else if (!edge_bus.valid || edge_taken) begin
            if (send_idle > 0) begin
                edge_bus.valid <= 1'b0;
                send_idle = send_idle - 1;
            end else if (pending_edges.size() != 0) begin
                it = pending_edges.pop_front();
                edge_bus.valid     <= 1'b1;
                edge_bus.cmd       <= it.cmd;
                edge_bus.timestamp <= it.ts;
                send_idle = draw_idle(send_calm);
            end else begin
                edge_bus.valid <= 1'b0;
            end
        end
    end

    // Result sink: stalls for a drawn number of cycles after each word.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            if (res_taken) recv_idle = draw_idle(recv_calm);
            if (recv_idle > 0) begin
                res_bus.ready <= 1'b0;
                recv_idle = recv_idle - 1;
            end else begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    // Prediction on accepted edges, checking on accepted results.
    always @(posedge i_clk) begin
        t_result want, got;
        edge_taken <= i_rst_n && edge_bus.valid && edge_bus.ready;
        res_taken  <= i_rst_n && res_bus.valid && res_bus.ready;
        if (i_rst_n && edge_bus.valid && edge_bus.ready) begin
            decode_edge(edge_bus.cmd, edge_bus.timestamp, want);
            expected_decodes.push_back(want);
        end
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            got.accepted            = res_bus.accepted;
            got.tooth_number        = res_bus.tooth_number;
            got.in_sync             = res_bus.in_sync;
            got.second_revolution   = res_bus.second_revolution;
            got.revolutions         = res_bus.revolutions;
            got.sync_losses         = res_bus.sync_losses;
            got.last_tooth_time     = res_bus.last_tooth_time;
            got.prev_tooth_time     = res_bus.prev_tooth_time;
            got.tooth_one_time      = res_bus.tooth_one_time;
            got.prev_tooth_one_time = res_bus.prev_tooth_one_time;
            if (expected_decodes.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("unexpected result at cycle %0d: %s", cycle_cnt, show(got));
            end else begin
                want = expected_decodes.pop_front();
                checked_cnt++;
                if (got.accepted === 1'b1) passed_cnt++;
                if (got !== want) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS) begin
                        $display("mismatch on result %0d at cycle %0d", checked_cnt, cycle_cnt);
                        $display("  expected %s", show(want));
                        $display("  actual   %s", show(got));
                    end
                end
            end
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout with %0d results still outstanding", expected_decodes.size());
        $display("Some tests failed");
        $finish;
    end

    initial begin
        logic [7:0]  teeth_plan  [NUM_PHASES];
        logic        resync_plan [NUM_PHASES];
        logic [1:0]  filt_plan   [NUM_PHASES];
        logic [7:0]  teeth, junk;
        teeth_plan  = '{8'd36, 8'd1, 8'd255, 8'd0, 8'd4, 8'd12, 8'd20, 8'd2};
        resync_plan = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
        filt_plan   = '{FILT_OFF, FILT_3QUART, FILT_HALF, FILT_QUARTER,
                        FILT_3QUART, FILT_OFF, FILT_HALF, FILT_3QUART};
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = '0;
        i_cfg_data         = '0;
        edge_bus.valid     = 1'b0;
        edge_bus.cmd       = CMD_CRANK;
        edge_bus.timestamp = '0;
        res_bus.ready      = 1'b0;
        reset_model();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed start from reset values: a rejected cam, sync from the cam with three
        // teeth counted, a filtered glitch, a full revolution, the cam sync pulse, then
        // timestamps at the top of the range that wrap and saturate the cam filter.
        queue_edge(CMD_CRANK, 32'd100);
        queue_edge(CMD_CRANK, 32'd200);
        queue_edge(CMD_CAM,   32'd10);
        queue_edge(CMD_CRANK, 32'd300);
        queue_edge(CMD_CAM,   32'd350);
        queue_edge(CMD_CRANK, 32'd450);
        queue_edge(CMD_CRANK, 32'd460);
        queue_edge(CMD_CRANK, 32'd550);
        queue_edge(CMD_CRANK, 32'd650);
        queue_edge(CMD_CRANK, 32'd750);
        queue_edge(CMD_CAM,   32'd800);
        queue_edge(CMD_CAM,   32'd820);
        queue_edge(CMD_CRANK, 32'd850);
        queue_edge(CMD_CAM,   32'd1000);
        queue_edge(CMD_CRANK, 32'd1050);
        queue_edge(CMD_CRANK, 32'd1150);
        queue_edge(CMD_CAM,   32'd1200);
        queue_edge(CMD_CRANK, 32'hFFFF_FFFF);
        queue_edge(CMD_CAM,   32'hFFFF_FFFF);
        queue_edge(CMD_CRANK, 32'h0000_0000);
        queue_edge(CMD_CAM,   32'h0000_0000);
        queue_edge(CMD_CAM,   32'h7FFF_FFFF);
        queue_edge(CMD_CRANK, 32'h8000_0000);
        wait_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            teeth = (ph == 6) ? 8'($urandom_range(2, 60)) : teeth_plan[ph];
            write_cfg(REG_CRANK_TEETH, teeth);
            junk = 8'($urandom());
            write_cfg(REG_RESYNC, {junk[7:1], resync_plan[ph]});
            junk = 8'($urandom());
            write_cfg(REG_FILTER, {junk[7:2], filt_plan[ph]});
            if (ph == 3) write_cfg(REG_UNUSED, 8'($urandom()));
            @(negedge i_clk);
            i_cfg_we <= 1'b0;
            settings_cnt++;
            plan_phase(PHASE_ITEMS);
            wait_drained();
        end

        $display("Covered %0d crank and %0d cam edges over %0d register settings,",
                 crank_cnt, cam_cnt, settings_cnt + 1);
        $display("with 0, 1 and 255 teeth; %0d results checked, %0d edges passed filters.",
                 checked_cnt, passed_cnt);
        if (mismatch_cnt == 0 && expected_decodes.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", mismatch_cnt);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
